[hw/rtl/chce_pkg.sv]
// Shared types and constants for the cubic Hermite curve evaluator.
// No dependencies; chce_div, the top module and the testbench refer to this package.
package chce_pkg;

    // Fractional bits of every fixed-point value (Q16.16).
    localparam int FRAC_BITS = 16;
    // Quotient width of tau, which lies in [0, 2^FRAC_BITS].
    localparam int QW = FRAC_BITS + 1;
    // Signed width of the Hermite basis weights.
    localparam int HW = QW + 3;
    // Accumulator width of one coordinate blend.
    localparam int ACC_W = 72;

    localparam int IN_DATA_W  = 272;
    localparam int OUT_DATA_W = 96;

    // Function codes carried in the input tuser.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    // Three coordinates, x in the lowest bits.
    typedef logic [2:0][31:0] t_vec3;

    // One spline node as it sits in the node table, knot in the lowest bits.
    typedef struct packed {
        t_vec3       tangent;
        t_vec3       point;
        logic [31:0] knot;
    } t_node;

    // Data that rides beside the divider.
    typedef struct packed {
        logic  err;
        t_vec3 p0;
        t_vec3 p1;
        t_vec3 d0;
        t_vec3 d1;
    } t_div_side;

endpackage

[hw/rtl/chce_ram.sv]
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module chce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/chce_div.sv]
// Pipelined restoring divider for tau = (t << FRAC_BITS) / tk, one quotient bit per stage.
// Depends on chce_pkg.
module chce_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  logic                i_valid,
    input  logic [30:0]         i_num,
    input  logic [31:0]         i_den,
    input  chce_pkg::t_div_side i_side,
    output logic                o_valid,
    output logic [chce_pkg::QW-1:0] o_quot,
    output logic [31:0]         o_den,
    output chce_pkg::t_div_side o_side
);

    localparam int QW = chce_pkg::QW;

    logic                r_valid [QW];
    logic [31:0]         r_rem   [QW];
    logic [QW-1:0]       r_quot  [QW];
    logic [31:0]         r_den   [QW];
    chce_pkg::t_div_side r_side  [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic                src_valid;
        logic [32:0]         src_part;
        logic [31:0]         src_den;
        logic [QW-1:0]       src_quot;
        chce_pkg::t_div_side src_side;
        logic                n_bit;
        logic [32:0]         n_diff;
        logic [31:0]         n_rem;

        if (g == 0) begin : g_first
            // The numerator's low bits are zero, so the first step sees t alone.
            assign src_valid = i_valid;
            assign src_part  = {2'b00, i_num};
            assign src_den   = i_den;
            assign src_quot  = '0;
            assign src_side  = i_side;
        end else begin : g_next
            assign src_valid = r_valid[g-1];
            assign src_part  = {r_rem[g-1], 1'b0};
            assign src_den   = r_den[g-1];
            assign src_quot  = r_quot[g-1];
            assign src_side  = r_side[g-1];
        end

        always_comb begin
            n_diff = src_part - {1'b0, src_den};
            n_bit  = (src_part >= {1'b0, src_den});
            n_rem  = n_bit ? n_diff[31:0] : src_part[31:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_ce) begin
                r_valid[g] <= src_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[g]  <= n_rem;
                r_quot[g] <= {src_quot[QW-2:0], n_bit};
                r_den[g]  <= src_den;
                r_side[g] <= src_side;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quot  = r_quot[QW-1];
    assign o_den   = r_den[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

[hw/rtl/cubic_hermite_curve_eval_unit.sv]
// Cubic Hermite 3D curve evaluator: node table, tau divider and blend pipeline.
// Throughput one item per cycle while no result waits at the output.
// The pipeline is made of the 17 stages of the tau divider plus ten stages of table read and blend.
// Reset (i_rst_n, synchronous, active low) clears all valid bits and sets num_segments to 1.
// The node table is not cleared; nodes must be written before a segment that uses them is evaluated.
// Depends on chce_pkg, chce_ram and chce_div.
module cubic_hermite_curve_eval_unit #(
    parameter int MAX_NODES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write channel: num_segments.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [5:0]   i_cfg_data,
    // Input stream.
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata from bit 0: node_index(6), knot_value(32), point_x, point_y, point_z,
    // tangent_x, tangent_y, tangent_z (32 each), segment(6), t_offset(31), zero fill.
    input  logic [chce_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // tuser: func (0 write node, 1 evaluate).
    input  logic [0:0]   i_s_axis_tuser,
    // Output stream.
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata from bit 0: curve_x, curve_y, curve_z (32 each).
    output logic [chce_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser: range_error.
    output logic [0:0]   o_m_axis_tuser
);

    localparam int AW    = $clog2(MAX_NODES);
    localparam int NW    = $bits(chce_pkg::t_node);
    localparam int FB    = chce_pkg::FRAC_BITS;
    localparam int QW    = chce_pkg::QW;
    localparam int HW    = chce_pkg::HW;
    localparam int PW    = HW + 33;
    localparam int GW    = PW - FB;
    localparam int ACC_W = chce_pkg::ACC_W;
    localparam int SW    = ACC_W - FB;

    // The whole pipeline advances together; it holds only while a result waits.
    logic ce;
    logic accept;
    assign ce              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = ce;
    assign accept          = i_s_axis_tvalid && ce;

    // Configuration register. Writes are taken at any time.
    logic [5:0] r_num_seg;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_seg <= 6'd1;
        end else if (i_cfg_valid) begin
            r_num_seg <= i_cfg_data;
        end
    end

    // Input fields.
    logic [5:0]  in_index;
    logic [5:0]  in_seg;
    logic [6:0]  in_seg_next;
    logic [30:0] in_t;
    logic        in_eval;
    assign in_index    = i_s_axis_tdata[5:0];
    assign in_seg      = i_s_axis_tdata[235:230];
    assign in_t        = i_s_axis_tdata[266:236];
    assign in_eval     = (i_s_axis_tuser[0] == chce_pkg::FUNC_EVAL);
    assign in_seg_next = {1'b0, in_seg} + 7'd1;

    // Node table, held twice so that both ends of a segment are read in one cycle.
    // A write transaction goes straight into both copies and leaves the pipeline.
    logic         tbl_we;
    chce_pkg::t_node rd_a;
    chce_pkg::t_node rd_b;
    logic [NW-1:0]   rd_a_bits;
    logic [NW-1:0]   rd_b_bits;
    assign tbl_we = accept && !in_eval && (int'(in_index) < MAX_NODES);

    chce_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_tbl_a (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_waddr(AW'(in_index)),
        .i_wdata(i_s_axis_tdata[NW+5:6]),
        .i_re   (ce),
        .i_raddr(AW'(in_seg)),
        .o_rdata(rd_a_bits)
    );

    chce_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_tbl_b (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_waddr(AW'(in_index)),
        .i_wdata(i_s_axis_tdata[NW+5:6]),
        .i_re   (ce),
        .i_raddr(AW'(in_seg_next)),
        .o_rdata(rd_b_bits)
    );

    assign rd_a = chce_pkg::t_node'(rd_a_bits);
    assign rd_b = chce_pkg::t_node'(rd_b_bits);

    // Stage 1: segment range check, alongside the table read.
    logic        r_s1_valid;
    logic        r_s1_err;
    logic [30:0] r_s1_t;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (ce) begin
            r_s1_valid <= accept && in_eval;
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s1_err <= (in_seg >= r_num_seg) || (int'(in_seg) + 1 >= MAX_NODES);
            r_s1_t   <= in_t;
        end
    end

    // Stage 2: span tk and the span and offset checks.
    logic signed [32:0] s1_tk;
    logic               s1_bad;
    assign s1_tk  = $signed({rd_b.knot[31], rd_b.knot}) - $signed({rd_a.knot[31], rd_a.knot});
    assign s1_bad = r_s1_err || (s1_tk <= 33'sd0) || ($signed({2'b00, r_s1_t}) > s1_tk);

    logic                r_s2_valid;
    logic [30:0]         r_s2_t;
    logic [31:0]         r_s2_tk;
    chce_pkg::t_div_side r_s2_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (ce) begin
            r_s2_valid <= r_s1_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s2_t         <= r_s1_t;
            r_s2_tk        <= s1_tk[31:0];
            r_s2_side.err  <= s1_bad;
            r_s2_side.p0   <= rd_a.point;
            r_s2_side.p1   <= rd_b.point;
            r_s2_side.d0   <= rd_a.tangent;
            r_s2_side.d1   <= rd_b.tangent;
        end
    end

    // Divider: tau = (t << FRAC_BITS) / tk.
    logic                dv_valid;
    logic [QW-1:0]       dv_quot;
    logic [31:0]         dv_den;
    chce_pkg::t_div_side dv_side;

    chce_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (ce),
        .i_valid(r_s2_valid),
        .i_num  (r_s2_t),
        .i_den  (r_s2_tk),
        .i_side (r_s2_side),
        .o_valid(dv_valid),
        .o_quot (dv_quot),
        .o_den  (dv_den),
        .o_side (dv_side)
    );

    // Stage 3: tau squared.
    logic [2*QW-1:0]     s3_sq;
    assign s3_sq = dv_quot * dv_quot;

    logic                r_s3_valid;
    logic [QW-1:0]       r_s3_tau;
    logic [QW-1:0]       r_s3_tau2;
    logic [31:0]         r_s3_tk;
    chce_pkg::t_div_side r_s3_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (ce) begin
            r_s3_valid <= dv_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s3_tau  <= dv_quot;
            r_s3_tau2 <= s3_sq[FB+QW-1:FB];
            r_s3_tk   <= dv_den;
            r_s3_side <= dv_side;
        end
    end

    // Stage 4: tau cubed.
    logic [2*QW-1:0]     s4_cube;
    assign s4_cube = r_s3_tau2 * r_s3_tau;

    logic                r_s4_valid;
    logic [QW-1:0]       r_s4_tau;
    logic [QW-1:0]       r_s4_tau2;
    logic [QW-1:0]       r_s4_tau3;
    logic [31:0]         r_s4_tk;
    chce_pkg::t_div_side r_s4_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (ce) begin
            r_s4_valid <= r_s3_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s4_tau  <= r_s3_tau;
            r_s4_tau2 <= r_s3_tau2;
            r_s4_tau3 <= s4_cube[FB+QW-1:FB];
            r_s4_tk   <= r_s3_tk;
            r_s4_side <= r_s3_side;
        end
    end

    // Stage 5: Hermite basis weights.
    logic signed [HW-1:0] s4_a;
    logic signed [HW-1:0] s4_a2;
    logic signed [HW-1:0] s4_a3;
    logic signed [HW-1:0] s4_one;
    assign s4_a   = $signed({3'b000, r_s4_tau});
    assign s4_a2  = $signed({3'b000, r_s4_tau2});
    assign s4_a3  = $signed({3'b000, r_s4_tau3});
    assign s4_one = HW'(1 << FB);

    logic                 r_s5_valid;
    logic signed [HW-1:0] r_s5_h00;
    logic signed [HW-1:0] r_s5_h01;
    logic signed [HW-1:0] r_s5_h10;
    logic signed [HW-1:0] r_s5_h11;
    logic [31:0]          r_s5_tk;
    chce_pkg::t_div_side  r_s5_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (ce) begin
            r_s5_valid <= r_s4_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s5_h00  <= (s4_a3 <<< 1) - (s4_a2 + (s4_a2 <<< 1)) + s4_one;
            r_s5_h01  <= (s4_a2 + (s4_a2 <<< 1)) - (s4_a3 <<< 1);
            r_s5_h10  <= s4_a3 - (s4_a2 <<< 1) + s4_a;
            r_s5_h11  <= s4_a3 - s4_a2;
            r_s5_tk   <= r_s4_tk;
            r_s5_side <= r_s4_side;
        end
    end

    // Stage 6: tangent weights scaled by the span.
    logic signed [32:0] s5_tk;
    assign s5_tk = $signed({1'b0, r_s5_tk});

    logic                 r_s6_valid;
    logic signed [PW-1:0] r_s6_p10;
    logic signed [PW-1:0] r_s6_p11;
    logic signed [HW-1:0] r_s6_h00;
    logic signed [HW-1:0] r_s6_h01;
    chce_pkg::t_div_side  r_s6_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (ce) begin
            r_s6_valid <= r_s5_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s6_p10  <= r_s5_h10 * s5_tk;
            r_s6_p11  <= r_s5_h11 * s5_tk;
            r_s6_h00  <= r_s5_h00;
            r_s6_h01  <= r_s5_h01;
            r_s6_side <= r_s5_side;
        end
    end

    // Stage 7: the four weighted terms of each coordinate. Dropping the low
    // fraction bits of a two's complement product rounds toward minus infinity.
    logic signed [GW-1:0] s6_g10;
    logic signed [GW-1:0] s6_g11;
    assign s6_g10 = r_s6_p10[PW-1:FB];
    assign s6_g11 = r_s6_p11[PW-1:FB];

    logic                    r_s7_valid;
    logic                    r_s7_err;
    logic signed [ACC_W-1:0] r_s7_m00 [3];
    logic signed [ACC_W-1:0] r_s7_m01 [3];
    logic signed [ACC_W-1:0] r_s7_m10 [3];
    logic signed [ACC_W-1:0] r_s7_m11 [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else if (ce) begin
            r_s7_valid <= r_s6_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s7_err <= r_s6_side.err;
            for (int k = 0; k < 3; k++) begin
                r_s7_m00[k] <= r_s6_h00 * $signed(r_s6_side.p0[k]);
                r_s7_m01[k] <= r_s6_h01 * $signed(r_s6_side.p1[k]);
                r_s7_m10[k] <= s6_g10 * $signed(r_s6_side.d0[k]);
                r_s7_m11[k] <= s6_g11 * $signed(r_s6_side.d1[k]);
            end
        end
    end

    // Stage 8: pairwise sums.
    logic                    r_s8_valid;
    logic                    r_s8_err;
    logic signed [ACC_W-1:0] r_s8_pa [3];
    logic signed [ACC_W-1:0] r_s8_pb [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_valid <= 1'b0;
        end else if (ce) begin
            r_s8_valid <= r_s7_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s8_err <= r_s7_err;
            for (int k = 0; k < 3; k++) begin
                r_s8_pa[k] <= r_s7_m00[k] + r_s7_m01[k];
                r_s8_pb[k] <= r_s7_m10[k] + r_s7_m11[k];
            end
        end
    end

    // Stage 9: full blend.
    logic                    r_s9_valid;
    logic                    r_s9_err;
    logic signed [ACC_W-1:0] r_s9_acc [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_valid <= 1'b0;
        end else if (ce) begin
            r_s9_valid <= r_s8_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s9_err <= r_s8_err;
            for (int k = 0; k < 3; k++) begin
                r_s9_acc[k] <= r_s8_pa[k] + r_s8_pb[k];
            end
        end
    end

    // Output register: scale down, saturate to 32 bits, force zero on error.
    chce_pkg::t_vec3 n_out;
    always_comb begin
        logic signed [SW-1:0] sh;
        for (int k = 0; k < 3; k++) begin
            sh = r_s9_acc[k][ACC_W-1:FB];
            if (r_s9_err) begin
                n_out[k] = '0;
            end else if (sh > SW'(64'sh7FFF_FFFF)) begin
                n_out[k] = 32'h7FFF_FFFF;
            end else if (sh < -SW'(64'sh8000_0000)) begin
                n_out[k] = 32'h8000_0000;
            end else begin
                n_out[k] = sh[31:0];
            end
        end
    end

    logic            r_out_valid;
    chce_pkg::t_vec3 r_out_data;
    logic            r_out_err;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ce) begin
            r_out_valid <= r_s9_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out_data <= n_out;
            r_out_err  <= r_s9_err;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_err;

`ifndef SYNTHESIS
    // An error result always carries a zero point.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("error result with nonzero point");

    // Without a waiting result the pipeline must take input.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("pipeline stalled with no result waiting");

    // tau of a good evaluation never exceeds one.
    a_tau_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && !r_s3_side.err) |-> (r_s3_tau <= QW'(1 << FB)))
        else $error("tau above one");

    // Reset restores the segment count.
    a_reset_cfg: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_num_seg == 6'd1))
        else $error("num_segments not restored by reset");
`endif

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for cubic_hermite_curve_eval_unit: node writes, evaluations, errors.
// Depends on chce_pkg and the block's RTL; holds its own Hermite predictor and result queue.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit              func;
        logic [5:0]      node_index;
        logic [31:0]     knot;
        chce_pkg::t_vec3 pnt;
        chce_pkg::t_vec3 tan;
        logic [5:0]      segment;
        logic [30:0]     t_offset;
    } t_item;

    typedef struct packed {
        chce_pkg::t_vec3 xyz;
        logic            err;
    } t_curve;

    // One row of the directed table: an item, or a register write when is_cfg is set.
    typedef struct {
        bit         is_cfg;
        logic [5:0] cfg_val;
        t_item      it;
        bit         has_exp;
        t_curve     exp_val;
    } t_row;

    localparam int  NODES = 64;
    localparam int  DRAIN = 40;   // more than the depth of the pipeline

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [5:0] i_cfg_data = '0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [chce_pkg::IN_DATA_W-1:0] i_s_axis_tdata = '0;
    logic [0:0] i_s_axis_tuser = '0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [chce_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [0:0] o_m_axis_tuser;

    cubic_hermite_curve_eval_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Predictor state: the node table as the block should hold it, and the register.
    longint     node_knot [NODES];
    longint     node_pnt  [NODES][3];
    longint     node_tan  [NODES][3];
    logic [5:0] num_seg;

    t_curve pending_curves[$];
    int     fail_count = 0;
    int     results_seen = 0;
    int     burst_left = 0;

    function automatic void store_node(t_item it);
        int k;
        node_knot[it.node_index] = longint'($signed(it.knot));
        for (k = 0; k < 3; k++) begin
            node_pnt[it.node_index][k] = longint'($signed(it.pnt[k]));
            node_tan[it.node_index][k] = longint'($signed(it.tan[k]));
        end
    endfunction

    // Hermite blend of one segment; all right shifts of signed values floor.
    function automatic t_curve eval_curve(logic [5:0] seg, logic [30:0] t);
        longint one, tk, tau, tau2, tau3, h00, h01, h10, h11, g10, g11, acc, v;
        t_curve r;
        int k;
        one = longint'(1) <<< chce_pkg::FRAC_BITS;
        r = '0;
        r.err = 1'b1;
        if (seg >= num_seg || int'(seg) + 1 >= NODES) return r;
        tk = node_knot[seg + 1] - node_knot[seg];
        if (tk <= 0 || longint'(t) > tk) return r;
        tau  = (longint'(t) <<< chce_pkg::FRAC_BITS) / tk;
        tau2 = (tau * tau) >>> chce_pkg::FRAC_BITS;
        tau3 = (tau2 * tau) >>> chce_pkg::FRAC_BITS;
        h00 = 2 * tau3 - 3 * tau2 + one;
        h01 = 3 * tau2 - 2 * tau3;
        h10 = tau3 - 2 * tau2 + tau;
        h11 = tau3 - tau2;
        g10 = (h10 * tk) >>> chce_pkg::FRAC_BITS;
        g11 = (h11 * tk) >>> chce_pkg::FRAC_BITS;
        for (k = 0; k < 3; k++) begin
            acc = h00 * node_pnt[seg][k] + h01 * node_pnt[seg + 1][k]
                + g10 * node_tan[seg][k] + g11 * node_tan[seg + 1][k];
            v = acc >>> chce_pkg::FRAC_BITS;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            r.xyz[k] = v[31:0];
        end
        r.err = 1'b0;
        return r;
    endfunction

    function automatic t_item node_item(logic [5:0] idx, logic [31:0] knot,
                                        chce_pkg::t_vec3 p, chce_pkg::t_vec3 d);
        t_item it;
        it = '{chce_pkg::FUNC_WRITE, idx, knot, p, d, 6'd0, 31'd0};
        return it;
    endfunction

    function automatic t_item eval_item(logic [5:0] seg, logic [30:0] t);
        t_item it;
        it = '{chce_pkg::FUNC_EVAL, 6'd0, 32'd0, '0, '0, seg, t};
        return it;
    endfunction

    // Offers one item, working in bursts with random gaps, and predicts it on acceptance.
    task automatic send_item(t_item it, bit has_exp = 1'b0, t_curve exp_val = '0);
        int gap;
        t_curve pred;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= it.func;
        i_s_axis_tdata  <= {5'd0, it.t_offset, it.segment, it.tan, it.pnt, it.knot,
                            it.node_index};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        burst_left--;
        if (it.func == chce_pkg::FUNC_WRITE) begin
            store_node(it);
        end else begin
            pred = eval_curve(it.segment, it.t_offset);
            pending_curves.push_back(has_exp ? exp_val : pred);
        end
    endtask

    // Waits for the pipeline to empty; node writes leave no result, so a drain follows.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_curves.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_num_seg(logic [5:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        num_seg = val;
        @(posedge i_clk);
    endtask

    // Receiver: random stalls in some stretches, always ready in others, and one long
    // hold-off once enough results have come so that the pipeline backs up.
    int  rx_cycle = 0;
    bit  rx_choppy = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_cnt = 0;
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0) rx_choppy <= $urandom_range(0, 1);
        if (!hold_done && hold_cnt == 0 && results_seen >= 400) begin
            hold_cnt <= 300;
            i_m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            if (hold_cnt == 1) hold_done <= 1'b1;
            i_m_axis_tready <= (hold_cnt == 1);
        end else begin
            i_m_axis_tready <= rx_choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    // Checks each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_curve want;
        int k;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen <= results_seen + 1;
            if (pending_curves.size() == 0) begin
                $error("result transaction with no expectation waiting");
                fail_count++;
            end else begin
                want = pending_curves.pop_front();
                for (k = 0; k < 3; k++) begin
                    if (o_m_axis_tdata[32*k +: 32] !== want.xyz[k]) begin
                        $error("curve_%0s: expected %h, got %h",
                               k == 0 ? "x" : k == 1 ? "y" : "z",
                               want.xyz[k], o_m_axis_tdata[32*k +: 32]);
                        fail_count++;
                    end
                end
                if (o_m_axis_tuser[0] !== want.err) begin
                    $error("range_error: expected %b, got %b", want.err, o_m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

    t_row rows[$];

    // Random node write: knots mostly rise with the index so spans are usable.
    task automatic random_write(int shift, int idx);
        chce_pkg::t_vec3 p, d;
        logic [31:0] knot;
        int k;
        for (k = 0; k < 3; k++) begin
            p[k] = ($urandom_range(0, 3) == 0) ? $urandom
                                               : $urandom_range(0, 32'h7FFFF) - 32'h40000;
            d[k] = ($urandom_range(0, 3) == 0) ? $urandom
                                               : $urandom_range(0, 32'h7FFFF) - 32'h40000;
        end
        if ($urandom_range(0, 9) < 8) begin
            knot = (idx << shift) + $urandom_range(0, 1 << (shift - 2));
        end else begin
            knot = $urandom;
        end
        send_item(node_item(idx[5:0], knot, p, d));
    endtask

    task automatic random_eval();
        logic [5:0] seg;
        longint tk, hi;
        logic [30:0] t;
        int pick;
        if (num_seg != 0 && $urandom_range(0, 9) < 8) seg = $urandom_range(0, num_seg - 1);
        else seg = $urandom_range(0, 63);
        tk = (seg < 63) ? node_knot[seg + 1] - node_knot[seg] : 0;
        pick = $urandom_range(0, 9);
        if (tk <= 0 || pick == 0) t = $urandom;
        else if (pick == 1) t = 31'd0;
        else if (pick == 2 && tk <= 64'h7FFFFFFF) t = tk[30:0];
        else if (pick == 3 && tk < 64'h7FFFFFFF) t = tk[30:0] + 31'd1;
        else begin
            hi = (tk > 64'h7FFFFFFF) ? 64'h7FFFFFFF : tk;
            t = $urandom_range(0, hi[31:0]);
        end
        send_item(eval_item(seg, t));
    endtask

    initial begin
        t_row r;
        t_curve err_res;
        int i, ph, n, shift;
        logic [5:0] phase_seg [4];

        num_seg = 6'd1;
        err_res = '0;
        err_res.err = 1'b1;

        // Directed table. Rows with a typed result are read straight off the definition:
        // errors give a zero point, and an offset at either end of a span gives its end point.
        r = '{1'b0, 6'd0, eval_item(6'd1, 31'd0), 1'b1, err_res};         rows.push_back(r);
        r.has_exp = 1'b0;
        r.it = node_item(6'd0, 32'h0, {32'h0, 32'h80000000, 32'h7FFFFFFF}, '0);
        rows.push_back(r);
        r.it = node_item(6'd1, 32'h10000, {32'h12345, 32'h7FFFFFFF, 32'h80000000},
                         {32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF});
        rows.push_back(r);
        r = '{1'b0, 6'd0, eval_item(6'd0, 31'd0), 1'b1,
              '{{32'h0, 32'h80000000, 32'h7FFFFFFF}, 1'b0}};              rows.push_back(r);
        r = '{1'b0, 6'd0, eval_item(6'd0, 31'h10000), 1'b1,
              '{{32'h12345, 32'h7FFFFFFF, 32'h80000000}, 1'b0}};          rows.push_back(r);
        r = '{1'b0, 6'd0, eval_item(6'd0, 31'h8000), 1'b0, '0};          rows.push_back(r);
        r = '{1'b0, 6'd0, eval_item(6'd0, 31'h10001), 1'b1, err_res};    rows.push_back(r);
        r = '{1'b0, 6'd0, eval_item(6'd63, 31'h7FFFFFFF), 1'b1, err_res}; rows.push_back(r);
        r = '{1'b1, 6'd63, eval_item(6'd0, 31'd0), 1'b0, '0};            rows.push_back(r);
        // Empty span between nodes 1 and 2, reversed span between nodes 2 and 3.
        r = '{1'b0, 6'd0, node_item(6'd2, 32'h10000, {32'd5, 32'd6, 32'd7}, {32'd1, 32'd2, 32'd3}),
              1'b0, '0};                                                  rows.push_back(r);
        r = '{1'b0, 6'd0, eval_item(6'd1, 31'd0), 1'b1, err_res};        rows.push_back(r);
        r = '{1'b0, 6'd0, node_item(6'd3, 32'h0, '0, '0), 1'b0, '0};     rows.push_back(r);
        r = '{1'b0, 6'd0, eval_item(6'd2, 31'd0), 1'b1, err_res};        rows.push_back(r);
        // Widest span: knot -2^31 at node 62 up to 2^31-1 at the last node.
        r = '{1'b0, 6'd0, node_item(6'd63, 32'h7FFFFFFF, {3{32'h7FFFFFFF}}, {3{32'h7FFFFFFF}}),
              1'b0, '0};                                                  rows.push_back(r);
        r = '{1'b0, 6'd0, node_item(6'd62, 32'h80000000, {3{32'h80000000}}, {3{32'h7FFFFFFF}}),
              1'b0, '0};                                                  rows.push_back(r);
        r = '{1'b0, 6'd0, eval_item(6'd62, 31'h7FFFFFFF), 1'b0, '0};     rows.push_back(r);
        r = '{1'b0, 6'd0, eval_item(6'd62, 31'h40000000), 1'b0, '0};     rows.push_back(r);
        r = '{1'b0, 6'd0, eval_item(6'd62, 31'd0), 1'b1,
              '{{3{32'h80000000}}, 1'b0}};                                rows.push_back(r);
        r = '{1'b1, 6'd0, eval_item(6'd0, 31'd0), 1'b0, '0};             rows.push_back(r);
        r = '{1'b0, 6'd0, eval_item(6'd0, 31'd0), 1'b1, err_res};        rows.push_back(r);
        r = '{1'b1, 6'd1, eval_item(6'd0, 31'd0), 1'b0, '0};             rows.push_back(r);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[j]) begin
            if (rows[j].is_cfg) write_num_seg(rows[j].cfg_val);
            else send_item(rows[j].it, rows[j].has_exp, rows[j].exp_val);
        end

        // Random phases, each under its own register setting, starting with a full table.
        phase_seg[0] = 6'd63;
        phase_seg[1] = $urandom_range(2, 62);
        phase_seg[2] = 6'd1;
        phase_seg[3] = 6'd63;
        for (ph = 0; ph < 4; ph++) begin
            write_num_seg(phase_seg[ph]);
            shift = $urandom_range(12, 24);
            if (ph == 0) for (i = 0; i < NODES; i++) random_write(shift, i);
            for (n = 0; n < 300; n++) begin
                if ($urandom_range(0, 3) == 0) random_write(shift, $urandom_range(0, 63));
                else random_eval();
            end
        end

        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_curves.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0 && pending_curves.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
